FILE: rtl/ansi_pkg.sv
// Package for the ANSI escape stripper: shared constants, enum types,
// the payload structs and the level classification function. No dependencies.
`timescale 1ns / 1ps

package ansi_pkg;

    localparam int MAX_LINE = 256;
    localparam int CNT_W    = $clog2(MAX_LINE + 1);
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 8;
    localparam int CAP_W    = 9;
    localparam int LEN_W    = 9;
    localparam int LVL_W    = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(240);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_LINE);

    localparam logic [BYTE_W-1:0] CH_ESC     = 8'h1B;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_FINAL_LO = 8'h40;
    localparam logic [BYTE_W-1:0] CH_FINAL_HI = 8'h7E;
    localparam logic [BYTE_W-1:0] CH_E       = 8'h45;
    localparam logic [BYTE_W-1:0] CH_W       = 8'h57;
    localparam logic [BYTE_W-1:0] CH_D       = 8'h44;
    localparam logic [BYTE_W-1:0] CH_V       = 8'h56;

    typedef enum logic [1:0] {
        ESC_NORMAL = 2'd0,
        ESC_AFTER  = 2'd1,
        ESC_IN_SEQ = 2'd2
    } t_esc_mode;

    typedef enum logic [LVL_W-1:0] {
        LVL_ERROR   = 3'd0,
        LVL_WARN    = 3'd1,
        LVL_INFO    = 3'd2,
        LVL_DEBUG   = 3'd3,
        LVL_VERBOSE = 3'd4
    } t_level;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              last_byte;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              kept;
        logic [POS_W-1:0]  position;
        logic              line_done;
        logic [LEN_W-1:0]  line_length;
        logic [LVL_W-1:0]  level_class;
        logic              line_valid;
    } t_result;

    function automatic t_level f_class_of(input logic [BYTE_W-1:0] b);
        t_level lvl;
        unique case (b)
            CH_E:    lvl = LVL_ERROR;
            CH_W:    lvl = LVL_WARN;
            CH_D:    lvl = LVL_DEBUG;
            CH_V:    lvl = LVL_VERBOSE;
            default: lvl = LVL_INFO;
        endcase
        return lvl;
    endfunction

endpackage

FILE: rtl/ansi_if.sv
// Valid/ready channel interfaces for the ANSI escape stripper: byte input,
// result output and configuration write. Depends on ansi_pkg.
`timescale 1ns / 1ps

interface ansi_in_if;
    import ansi_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              last_byte;
    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface ansi_out_if;
    import ansi_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              kept;
    logic [POS_W-1:0]  position;
    logic              line_done;
    logic [LEN_W-1:0]  line_length;
    logic [LVL_W-1:0]  level_class;
    logic              line_valid;
    modport source (output valid, output out_byte, output kept, output position,
                    output line_done, output line_length, output level_class,
                    output line_valid, input ready);
    modport sink   (input valid, input out_byte, input kept, input position,
                    input line_done, input line_length, input level_class,
                    input line_valid, output ready);
endinterface

interface ansi_cfg_if;
    import ansi_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ansi_in_stage.sv
// Input register stage of the ANSI escape stripper.
// Holds one accepted byte transaction until the line logic consumes it. Depends on ansi_pkg.
`timescale 1ns / 1ps

module ansi_in_stage
    import ansi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/ansi_line_fsm.sv
// Line state of the ANSI escape stripper: escape parser, kept count, trimmed
// length, level class and the capacity register. Depends on ansi_pkg and ansi_if.
`timescale 1ns / 1ps

module ansi_line_fsm
    import ansi_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    ansi_cfg_if.sink        i_cfg,
    input  logic            i_step,
    input  t_item           i_item,
    output t_result         o_result
);

    logic [CAP_W-1:0] r_cap;
    t_esc_mode        r_mode, n_mode;
    logic [CNT_W-1:0] r_kept_cnt, n_kept_cnt;
    logic [CNT_W-1:0] r_content_len, n_content_len;
    t_level           r_level, n_level;

    logic [CNT_W-1:0] cap_eff;
    logic             active;
    logic             is_final;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg.valid) begin
            r_cap <= i_cfg.data;
        end
    end

    // Capacities above the line buffer size act as the full buffer.
    assign cap_eff  = (r_cap > CAP_W'(MAX_LINE)) ? CAP_MAX : CNT_W'(r_cap);
    assign active   = (r_kept_cnt < cap_eff);
    assign is_final = (i_item.in_byte >= CH_FINAL_LO) && (i_item.in_byte <= CH_FINAL_HI);

    always_comb begin
        n_mode        = r_mode;
        n_kept_cnt    = r_kept_cnt;
        n_content_len = r_content_len;
        n_level       = r_level;
        o_result      = '0;
        o_result.out_byte  = i_item.in_byte;
        o_result.line_done = i_item.last_byte;

        // Once the line is full, escape parsing and keeping stop; the last byte still closes the line.
        if (active) begin
            unique case (r_mode)
                ESC_AFTER: begin
                    n_mode = ESC_IN_SEQ;
                end
                ESC_IN_SEQ: begin
                    if (is_final) begin
                        n_mode = ESC_NORMAL;
                    end
                end
                ESC_NORMAL: begin
                    if (i_item.in_byte == CH_ESC) begin
                        n_mode = ESC_AFTER;
                    end else begin
                        o_result.kept     = 1'b1;
                        o_result.position = r_kept_cnt[POS_W-1:0];
                        if (r_kept_cnt == '0) begin
                            n_level = f_class_of(i_item.in_byte);
                        end
                        n_kept_cnt = r_kept_cnt + CNT_W'(1);
                        if (i_item.in_byte != CH_LF && i_item.in_byte != CH_CR) begin
                            n_content_len = n_kept_cnt;
                        end
                    end
                end
                default: begin
                    n_mode = ESC_NORMAL;
                end
            endcase
        end

        if (i_item.last_byte) begin
            o_result.line_length = LEN_W'(n_content_len);
            o_result.level_class = n_level;
            o_result.line_valid  = (n_content_len != '0);
            n_mode        = ESC_NORMAL;
            n_kept_cnt    = '0;
            n_content_len = '0;
            n_level       = LVL_INFO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ESC_NORMAL;
            r_kept_cnt    <= '0;
            r_content_len <= '0;
            r_level       <= LVL_INFO;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_kept_cnt    <= n_kept_cnt;
            r_content_len <= n_content_len;
            r_level       <= n_level;
        end
    end

    a_len_within_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_content_len <= r_kept_cnt)
        else $error("trimmed length exceeds kept count");

    a_kept_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_cnt <= CAP_MAX)
        else $error("kept count beyond line buffer size");

    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.last_byte |=> r_kept_cnt == '0 && r_mode == ESC_NORMAL)
        else $error("line state not cleared after last byte");

    a_kept_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.kept && !i_item.last_byte
        |=> r_kept_cnt == $past(r_kept_cnt) + CNT_W'(1))
        else $error("kept byte did not advance the count");

endmodule

FILE: rtl/ansi_out_stage.sv
// Result register of the ANSI escape stripper, driving the output channel.
// Depends on ansi_pkg and ansi_if.
`timescale 1ns / 1ps

module ansi_out_stage
    import ansi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_free,
    ansi_out_if.source o_out
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // The register can take a new result when empty or when its current
    // transaction completes in this cycle.
    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_res.out_byte;
    assign o_out.kept        = r_res.kept;
    assign o_out.position    = r_res.position;
    assign o_out.line_done   = r_res.line_done;
    assign o_out.line_length = r_res.line_length;
    assign o_out.level_class = r_res.level_class;
    assign o_out.line_valid  = r_res.line_valid;

endmodule

FILE: rtl/ansi_escape_stripper_unit.sv
// ANSI escape stripper: takes one log byte per transaction and returns one
// result per byte. It sustains one byte per clock cycle while results are taken.
// An accepted byte is held in the input register, and its result is then loaded
// into the result register. The rate is set by the line state loop (escape
// mode, kept count, trimmed length, level), which updates once per byte. A
// stalled result holds the input register and so stalls the input. The
// capacity register must only be written while the block is idle.
// Depends on ansi_pkg, ansi_if, ansi_in_stage, ansi_line_fsm and ansi_out_stage.
`timescale 1ns / 1ps

module ansi_escape_stripper_unit
    import ansi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ansi_cfg_if.sink   i_cfg,
    ansi_in_if.sink    i_in,
    ansi_out_if.source o_out
);

    t_item   in_item;
    t_item   stage_item;
    t_result result;
    logic    stage_valid;
    logic    out_free;
    logic    step;
    logic    load_in;

    assign in_item.in_byte   = i_in.in_byte;
    assign in_item.last_byte = i_in.last_byte;

    assign step        = stage_valid && out_free;
    assign i_in.ready  = !stage_valid || step;
    assign load_in     = i_in.valid && i_in.ready;

    ansi_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load_in),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    ansi_line_fsm u_line_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_step   (step),
        .i_item   (stage_item),
        .o_result (result)
    );

    ansi_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for ansi_escape_stripper_unit: a table of directed bytes, then
// random log lines over several capacity settings, checked against an in-bench predictor.
// Depends on ansi_pkg, the channel interfaces in ansi_if and the unit under test.
`timescale 1ns / 1ps

module tb_top;
    import ansi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              fin;
        logic              typed;
        logic              kept;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        t_level            lvl;
        logic              vld;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ansi_cfg_if cfg_if ();
    ansi_in_if  in_if ();
    ansi_out_if out_if ();

    ansi_escape_stripper_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: one line in flight plus the capacity register.
    logic [CAP_W-1:0] cap_reg;
    t_esc_mode        esc_state;
    int               kept_cnt;
    int               trimmed_len;
    t_level           lvl_first;

    t_result          expected_q[$];
    t_item            line_buf[$];
    bit               no_idle;
    int               mismatch_cnt;
    int               cycle_cnt;
    int               bytes_sent;
    int               lines_closed;
    int               kept_seen;

    // Opening rows use capacity 240 straight out of reset.
    t_dir_row dir_rows [27] = '{
        '{8'h45, 1'b0, 1'b1, 1'b1, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h1B, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h5B, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h33, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h6D, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h78, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h0D, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h0A, 1'b1, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b1, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'hFF, 1'b1, 1'b1, 1'b1, 8'd1, 9'd2, LVL_INFO,    1'b1},
        '{8'h57, 1'b1, 1'b1, 1'b1, 8'd0, 9'd1, LVL_WARN,    1'b1},
        '{8'h44, 1'b1, 1'b1, 1'b1, 8'd0, 9'd1, LVL_DEBUG,   1'b1},
        '{8'h56, 1'b1, 1'b1, 1'b1, 8'd0, 9'd1, LVL_VERBOSE, 1'b1},
        '{8'h49, 1'b1, 1'b1, 1'b1, 8'd0, 9'd1, LVL_INFO,    1'b1},
        '{8'h1B, 1'b1, 1'b1, 1'b0, 8'd0, 9'd0, LVL_INFO,    1'b0},
        '{8'h40, 1'b1, 1'b1, 1'b1, 8'd0, 9'd1, LVL_INFO,    1'b1},
        '{8'h0A, 1'b0, 1'b1, 1'b1, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h0D, 1'b1, 1'b1, 1'b1, 8'd1, 9'd0, LVL_INFO,    1'b0},
        '{8'h1B, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h1B, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h3F, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h7E, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h1B, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h78, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h40, 1'b0, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0},
        '{8'h41, 1'b1, 1'b0, 1'b0, 8'd0, 9'd0, LVL_ERROR,   1'b0}
    };

    function automatic t_level level_for(input logic [BYTE_W-1:0] b);
        if (b == CH_E) return LVL_ERROR;
        if (b == CH_W) return LVL_WARN;
        if (b == CH_D) return LVL_DEBUG;
        if (b == CH_V) return LVL_VERBOSE;
        return LVL_INFO;
    endfunction

    function automatic void clear_line_state();
        esc_state   = ESC_NORMAL;
        kept_cnt    = 0;
        trimmed_len = 0;
        lvl_first   = LVL_INFO;
    endfunction

    // Advances the line state by one byte and returns the result it must produce.
    function automatic t_result strip_predict(input logic [BYTE_W-1:0] b, input logic fin);
        t_result r;
        int      lim;
        r           = '0;
        r.out_byte  = b;
        r.line_done = fin;
        lim = (cap_reg > MAX_LINE) ? MAX_LINE : int'(cap_reg);
        // Once the line is full, escape parsing stops as well.
        if (kept_cnt < lim) begin
            case (esc_state)
                ESC_AFTER: esc_state = ESC_IN_SEQ;
                ESC_IN_SEQ: begin
                    if (b >= CH_FINAL_LO && b <= CH_FINAL_HI) esc_state = ESC_NORMAL;
                end
                default: begin
                    if (b == CH_ESC) begin
                        esc_state = ESC_AFTER;
                    end else begin
                        r.kept     = 1'b1;
                        r.position = POS_W'(kept_cnt);
                        if (kept_cnt == 0) lvl_first = level_for(b);
                        kept_cnt++;
                        if (b != CH_LF && b != CH_CR) trimmed_len = kept_cnt;
                    end
                end
            endcase
        end
        if (fin) begin
            r.line_length = LEN_W'(trimmed_len);
            r.level_class = lvl_first;
            r.line_valid  = (trimmed_len != 0);
            clear_line_state();
        end
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, fname, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cap_reg = v;
    endtask

    // Sends one byte after a random gap; the expectation is pushed at the transaction.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fin,
                             input bit typed, input t_result typed_res);
        int      gap;
        t_result predicted;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.in_byte   <= b;
        in_if.last_byte <= fin;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = strip_predict(b, fin);
        expected_q.push_back(typed ? typed_res : predicted);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Appends one log line to line_buf: mostly well-formed text with CSI sequences,
    // sometimes raw noise or a sequence that never sees its final byte.
    task automatic gen_line(input bit force_long);
        logic [BYTE_W-1:0] bytes[$];
        int                n;
        int                nseg;
        t_item             it;
        if (force_long) begin
            n = $urandom_range(240, 290);
            repeat (n) bytes.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
            bytes.push_back(CH_LF);
        end else if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 5))
                0: bytes.push_back(CH_E);
                1: bytes.push_back(CH_W);
                2: bytes.push_back(8'h49);
                3: bytes.push_back(CH_D);
                4: bytes.push_back(CH_V);
                default: ;
            endcase
            nseg = $urandom_range(0, 5);
            repeat (nseg) begin
                if ($urandom_range(0, 1) == 0) begin
                    n = $urandom_range(1, 8);
                    repeat (n) bytes.push_back(BYTE_W'($urandom_range(8'h20, 8'h7E)));
                end else begin
                    bytes.push_back(CH_ESC);
                    if ($urandom_range(0, 7) == 0)
                        bytes.push_back(BYTE_W'($urandom_range(0, 255)));
                    else
                        bytes.push_back(8'h5B);
                    n = $urandom_range(0, 4);
                    repeat (n) bytes.push_back(BYTE_W'($urandom_range(8'h30, 8'h3F)));
                    if ($urandom_range(0, 9) != 0)
                        bytes.push_back(BYTE_W'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
                end
            end
            case ($urandom_range(0, 3))
                1: bytes.push_back(CH_LF);
                2: begin
                    bytes.push_back(CH_CR);
                    bytes.push_back(CH_LF);
                end
                3: bytes.push_back(CH_CR);
                default: ;
            endcase
            if (bytes.size() == 0) bytes.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        foreach (bytes[i]) begin
            it.in_byte   = bytes[i];
            it.last_byte = (i == bytes.size() - 1);
            line_buf.push_back(it);
        end
    endtask

    // A phase may stop in the middle of a line, so the next capacity applies mid-line.
    task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items);
        wait_drained();
        set_capacity(cap);
        no_idle = ($urandom_range(0, 3) == 0);
        line_buf.delete();
        gen_line(n_items >= 300);
        while (line_buf.size() < n_items) gen_line(1'b0);
        for (int i = 0; i < n_items; i++)
            push_byte(line_buf[i].in_byte, line_buf[i].last_byte, 1'b0, '0);
        in_if.valid <= 1'b0;
    endtask

    // Result side: random stalls per result, compared against the oldest expectation.
    initial begin : result_sink
        int      stall;
        t_result got;
        t_result want;
        out_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            got.out_byte    = out_if.out_byte;
            got.kept        = out_if.kept;
            got.position    = out_if.position;
            got.line_done   = out_if.line_done;
            got.line_length = out_if.line_length;
            got.level_class = out_if.level_class;
            got.line_valid  = out_if.line_valid;
            if (expected_q.size() == 0) begin
                $display("%0t ns: unexpected result transaction, byte 0x%0h",
                         $time, got.out_byte);
                mismatch_cnt++;
            end else begin
                want = expected_q.pop_front();
                check_field("out_byte", LEN_W'(want.out_byte), LEN_W'(got.out_byte));
                check_field("kept", LEN_W'(want.kept), LEN_W'(got.kept));
                check_field("position", LEN_W'(want.position), LEN_W'(got.position));
                check_field("line_done", LEN_W'(want.line_done), LEN_W'(got.line_done));
                check_field("line_length", want.line_length, got.line_length);
                check_field("level_class", LEN_W'(want.level_class),
                            LEN_W'(got.level_class));
                check_field("line_valid", LEN_W'(want.line_valid), LEN_W'(got.line_valid));
                if (want.line_done) lines_closed++;
                if (want.kept) kept_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_cnt, expected_q.size());
            $display("ansi_escape_stripper_unit: mismatch");
            $finish;
        end
    end

    initial begin : main_seq
        logic [CAP_W-1:0] cap_plan [NUM_PHASES];
        int               count_plan [NUM_PHASES];
        t_result          typed_res;
        cycle_cnt       = 0;
        mismatch_cnt    = 0;
        bytes_sent      = 0;
        lines_closed    = 0;
        kept_seen       = 0;
        no_idle         = 1'b0;
        i_rst_n         <= 1'b0;
        cfg_if.valid    <= 1'b0;
        cfg_if.data     <= '0;
        in_if.valid     <= 1'b0;
        in_if.in_byte   <= '0;
        in_if.last_byte <= 1'b0;
        cap_reg = CAP_RESET;
        clear_line_state();
        cap_plan   = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd2, 9'd255, 9'd300, 9'd7, 9'd240, 9'd16};
        count_plan = '{80, 300, 60, 300, 80, 300, 80, 80, 80, 80};
        cap_plan[7] = CAP_W'($urandom_range(3, 31));
        cap_plan[9] = CAP_W'($urandom_range(3, 31));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            typed_res.out_byte    = dir_rows[i].b;
            typed_res.kept        = dir_rows[i].kept;
            typed_res.position    = dir_rows[i].pos;
            typed_res.line_done   = dir_rows[i].fin;
            typed_res.line_length = dir_rows[i].len;
            typed_res.level_class = dir_rows[i].lvl;
            typed_res.line_valid  = dir_rows[i].vld;
            push_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed, typed_res);
        end
        in_if.valid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(cap_plan[p], count_plan[p]);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d bytes, %0d closed lines, %0d kept bytes", bytes_sent,
                 lines_closed, kept_seen);
        $display("over %0d capacity settings including 0, 1, 256 and 511", NUM_PHASES + 1);
        if (mismatch_cnt == 0) begin
            $display("ansi_escape_stripper_unit: match");
        end else begin
            $display("ansi_escape_stripper_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ansi_pkg.sv
rtl/ansi_if.sv
rtl/ansi_in_stage.sv
rtl/ansi_line_fsm.sv
rtl/ansi_out_stage.sv
rtl/ansi_escape_stripper_unit.sv
test/tb_top.sv
